[design/drive_motor_speed_ramp_unit_macros.svh]
// assertion macros for the drive motor speed ramp unit
// used by the top level only, no other dependencies
`ifndef DRIVE_MOTOR_SPEED_RAMP_UNIT_MACROS_SVH
`define DRIVE_MOTOR_SPEED_RAMP_UNIT_MACROS_SVH
`ifndef SYNTH
`define DRMP_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("drmp assertion failed");
`define DRMP_ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("drmp forbidden condition");
`else
`define DRMP_ASSERT(lbl, clk, rst_n, prop)
`define DRMP_ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

[design/drmp_pkg.sv]
// shared types and constants for the drive motor speed ramp unit
// no dependencies
`default_nettype none
package drmp_pkg;

    localparam int RAMP_STEPS = 8;
    localparam int CNT_W      = $clog2(RAMP_STEPS);
    localparam int SPEED_W    = 8;
    localparam int DUTY_W     = 10;
    localparam int HOLD_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    typedef logic [SPEED_W-1:0]    speed_t;
    typedef logic [DUTY_W-1:0]     duty_t;
    typedef logic [HOLD_W-1:0]     hold_t;
    typedef logic [CNT_W-1:0]      cnt_t;
    typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
    typedef logic [CFG_DATA_W-1:0] cfg_data_t;

    localparam cfg_idx_t REG_RAMP_THRESHOLD = 2'd0;
    localparam cfg_idx_t REG_BUMP_HOLD_MS   = 2'd1;
    localparam cfg_idx_t REG_BUMP_DUTY      = 2'd2;

    localparam speed_t RST_RAMP_THRESHOLD = 8'd31;
    localparam hold_t  RST_BUMP_HOLD_MS   = 8'd10;
    localparam duty_t  RST_BUMP_DUTY      = 10'd1023;

    localparam speed_t SPEED_MAX = 8'd255;

    typedef enum logic [1:0] {
        DIR_COAST = 2'd0,
        DIR_FWD   = 2'd1,
        DIR_REV   = 2'd2
    } dir_t;

    typedef enum logic [1:0] {
        STEP_DIR,
        STEP_BUMP,
        STEP_RAMP,
        STEP_FINAL
    } step_kind_t;

    typedef struct packed {
        logic       load;
        logic       eval;
        logic       emit;
        step_kind_t kind;
        logic       last;
    } cmd_t;

    typedef struct packed {
        logic dir_chg;
        logic rise;
        logic fall;
        logic bump;
        logic ramp;
        logic out_free;
    } status_t;

endpackage
`default_nettype wire

[design/drmp_datapath.sv]
// datapath: config registers, speed state, ramp accumulator and output register
// depends on drmp_pkg
`default_nettype none
module drmp_datapath (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic signed [8:0]   target_speed,
    input  wire logic                cfg_we,
    input  wire drmp_pkg::cfg_idx_t  cfg_index,
    input  wire drmp_pkg::cfg_data_t cfg_data,
    input  wire drmp_pkg::cmd_t      cmd,
    output drmp_pkg::status_t        status,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [9:0]               pwm_duty,
    output logic                     bridge_a,
    output logic                     bridge_b,
    output logic [7:0]               hold_ms,
    output logic                     last_step
);

    drmp_pkg::speed_t ramp_threshold_reg;
    drmp_pkg::hold_t  bump_hold_ms_reg;
    drmp_pkg::duty_t  bump_duty_reg;

    drmp_pkg::speed_t present_speed_reg;
    drmp_pkg::dir_t   present_dir_reg;

    drmp_pkg::speed_t mag_reg;
    drmp_pkg::speed_t mag_next;
    drmp_pkg::dir_t   dir_reg;
    drmp_pkg::dir_t   dir_next;

    drmp_pkg::speed_t sp_reg;
    drmp_pkg::speed_t sp_sum;
    drmp_pkg::speed_t frac_reg;
    drmp_pkg::speed_t start;
    drmp_pkg::speed_t diff;
    logic             dir_chg;

    logic dir_chg_reg;
    logic rise_reg;
    logic fall_reg;
    logic bump_reg;
    logic ramp_reg;

    logic              out_valid_reg;
    drmp_pkg::duty_t   duty_reg;
    drmp_pkg::duty_t   duty_next;
    drmp_pkg::hold_t   hold_reg;
    drmp_pkg::hold_t   hold_next;
    logic              last_reg;
    logic              bridge_a_next;
    logic              bridge_b_next;
    logic              bridge_a_reg;
    logic              bridge_b_reg;

    // command decode: magnitude with saturation, and direction
    always_comb
    begin
        if (target_speed == 9'sd0)
        begin
            mag_next = '0;
            dir_next = drmp_pkg::DIR_COAST;
        end
        else if (target_speed[8])
        begin
            dir_next = drmp_pkg::DIR_REV;
            if (target_speed == -9'sd256)
            begin
                mag_next = drmp_pkg::SPEED_MAX;
            end
            else
            begin
                mag_next = drmp_pkg::speed_t'(-target_speed);
            end
        end
        else
        begin
            mag_next = target_speed[7:0];
            dir_next = drmp_pkg::DIR_FWD;
        end
    end

    assign dir_chg = (dir_reg != present_dir_reg);
    assign start   = dir_chg ? '0 : present_speed_reg;
    assign diff    = mag_reg - start;
    assign sp_sum  = sp_reg + frac_reg;

    always_comb
    begin
        unique case (present_dir_reg)
            drmp_pkg::DIR_FWD:
            begin
                bridge_a_next = 1'b0;
                bridge_b_next = 1'b1;
            end
            drmp_pkg::DIR_REV:
            begin
                bridge_a_next = 1'b1;
                bridge_b_next = 1'b0;
            end
            default:
            begin
                bridge_a_next = 1'b1;
                bridge_b_next = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        unique case (cmd.kind)
            drmp_pkg::STEP_DIR:
            begin
                duty_next = '0;
                hold_next = '0;
            end
            drmp_pkg::STEP_BUMP:
            begin
                duty_next = bump_duty_reg;
                hold_next = bump_hold_ms_reg;
            end
            drmp_pkg::STEP_RAMP:
            begin
                duty_next = {sp_sum, 2'b00};
                hold_next = frac_reg;
            end
            default:
            begin
                duty_next = {mag_reg, 2'b00};
                hold_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ramp_threshold_reg <= drmp_pkg::RST_RAMP_THRESHOLD;
            bump_hold_ms_reg   <= drmp_pkg::RST_BUMP_HOLD_MS;
            bump_duty_reg      <= drmp_pkg::RST_BUMP_DUTY;
            present_speed_reg  <= '0;
            present_dir_reg    <= drmp_pkg::DIR_COAST;
            dir_reg            <= drmp_pkg::DIR_COAST;
            dir_chg_reg        <= 1'b0;
            rise_reg           <= 1'b0;
            fall_reg           <= 1'b0;
            bump_reg           <= 1'b0;
            ramp_reg           <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    drmp_pkg::REG_RAMP_THRESHOLD: ramp_threshold_reg <= cfg_data[7:0];
                    drmp_pkg::REG_BUMP_HOLD_MS:   bump_hold_ms_reg   <= cfg_data[7:0];
                    drmp_pkg::REG_BUMP_DUTY:      bump_duty_reg      <= cfg_data;
                    default:                      ;
                endcase
            end
            if (cmd.load)
            begin
                dir_reg <= dir_next;
            end
            if (cmd.eval)
            begin
                dir_chg_reg       <= dir_chg;
                rise_reg          <= (start < mag_reg);
                fall_reg          <= (start > mag_reg);
                bump_reg          <= (start < mag_reg) && (start == '0);
                ramp_reg          <= (start < mag_reg) && (diff > ramp_threshold_reg);
                present_dir_reg   <= dir_reg;
                present_speed_reg <= mag_reg;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mag_reg <= mag_next;
        end
        if (cmd.eval)
        begin
            sp_reg   <= start;
            frac_reg <= drmp_pkg::speed_t'(diff / drmp_pkg::RAMP_STEPS);
        end
        if (cmd.emit)
        begin
            duty_reg     <= duty_next;
            hold_reg     <= hold_next;
            last_reg     <= cmd.last;
            bridge_a_reg <= bridge_a_next;
            bridge_b_reg <= bridge_b_next;
            if (cmd.kind == drmp_pkg::STEP_RAMP)
            begin
                sp_reg <= sp_sum;
            end
        end
    end

    assign status.dir_chg  = dir_chg_reg;
    assign status.rise     = rise_reg;
    assign status.fall     = fall_reg;
    assign status.bump     = bump_reg;
    assign status.ramp     = ramp_reg;
    assign status.out_free = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign pwm_duty  = duty_reg;
    assign hold_ms   = hold_reg;
    assign last_step = last_reg;
    assign bridge_a  = bridge_a_reg;
    assign bridge_b  = bridge_b_reg;

endmodule
`default_nettype wire

[design/drmp_ctrl.sv]
// controller: sequences direction, bump, ramp and final steps of one command
// depends on drmp_pkg
`default_nettype none
module drmp_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire drmp_pkg::status_t status,
    output drmp_pkg::cmd_t         cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_PICK,
        S_DIR,
        S_BUMP,
        S_RAMP,
        S_FINAL
    } state_t;

    state_t         state_reg;
    state_t         state_next;
    state_t         first_state;
    state_t         after_state;
    state_t         rise_state;
    drmp_pkg::cnt_t cnt_reg;
    drmp_pkg::cnt_t cnt_next;

    // first step of a rise
    always_comb
    begin
        priority if (status.bump)
        begin
            rise_state = S_BUMP;
        end
        else if (status.ramp)
        begin
            rise_state = S_RAMP;
        end
        else
        begin
            rise_state = S_FINAL;
        end
    end

    always_comb
    begin
        priority if (status.dir_chg)
        begin
            first_state = S_DIR;
        end
        else if (status.rise)
        begin
            first_state = rise_state;
        end
        else if (status.fall)
        begin
            first_state = S_FINAL;
        end
        else
        begin
            first_state = S_IDLE;
        end
    end

    always_comb
    begin
        unique case (state_reg)
            S_DIR:
            begin
                priority if (status.rise)
                begin
                    after_state = rise_state;
                end
                else if (status.fall)
                begin
                    after_state = S_FINAL;
                end
                else
                begin
                    after_state = S_IDLE;
                end
            end
            S_BUMP:
            begin
                after_state = status.ramp ? S_RAMP : S_FINAL;
            end
            S_RAMP:
            begin
                after_state = (cnt_reg == drmp_pkg::cnt_t'(drmp_pkg::RAMP_STEPS - 1))
                              ? S_FINAL : S_RAMP;
            end
            default:
            begin
                after_state = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        in_ready   = (state_reg == S_IDLE);
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = S_PICK;
            end
            S_PICK:
            begin
                state_next = first_state;
                cnt_next   = drmp_pkg::cnt_t'(1);
            end
            default:
            begin
                unique case (state_reg)
                    S_DIR:   cmd.kind = drmp_pkg::STEP_DIR;
                    S_BUMP:  cmd.kind = drmp_pkg::STEP_BUMP;
                    S_RAMP:  cmd.kind = drmp_pkg::STEP_RAMP;
                    default: cmd.kind = drmp_pkg::STEP_FINAL;
                endcase
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.last   = (after_state == S_IDLE);
                    state_next = after_state;
                    if (state_reg == S_RAMP)
                    begin
                        cnt_next = cnt_reg + drmp_pkg::cnt_t'(1);
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule
`default_nettype wire

[design/drive_motor_speed_ramp_unit.sv]
// Drive motor speed ramp unit. A signed speed command produces 0 to
// RAMP_STEPS + 2 drive steps (duty, bridge pattern, hold time, last flag).
// After its transfer a command is decoded and evaluated against the present
// speed, then the controller puts one step per cycle into the output register
// whenever it is empty or being drained. The next command is taken as soon as
// the final step sits in the output register.
// Configuration writes take effect at once and are meant for idle periods.
// depends on drmp_pkg, drmp_ctrl, drmp_datapath, drive_motor_speed_ramp_unit_macros.svh
`default_nettype none
`include "drive_motor_speed_ramp_unit_macros.svh"
module drive_motor_speed_ramp_unit (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_we,
    input  wire drmp_pkg::cfg_idx_t  cfg_index,
    input  wire drmp_pkg::cfg_data_t cfg_data,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic signed [8:0]   target_speed,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [9:0]               pwm_duty,
    output logic                     bridge_a,
    output logic                     bridge_b,
    output logic [7:0]               hold_ms,
    output logic                     last_step
);

    drmp_pkg::cmd_t    cmd;
    drmp_pkg::status_t status;

    drmp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    drmp_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .target_speed (target_speed),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cmd          (cmd),
        .status       (status),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .pwm_duty     (pwm_duty),
        .bridge_a     (bridge_a),
        .bridge_b     (bridge_b),
        .hold_ms      (hold_ms),
        .last_step    (last_step)
    );

    // one command at a time
    `DRMP_ASSERT(a_one_cmd, clk, rst_n, (in_valid && in_ready) |=> !in_ready)
    // a step that is not the last one means the command is still in work
    `DRMP_ASSERT(a_busy_mid_cmd, clk, rst_n, (out_valid && !last_step) |-> !in_ready)
    // the bridge is never driven low on both inputs
    `DRMP_ASSERT_NEVER(a_bridge_short, clk, rst_n, out_valid && !bridge_a && !bridge_b)
    // an emitted step cannot be lost by the next one while stalled
    `DRMP_ASSERT(a_emit_slot, clk, rst_n, (cmd.emit) |-> (!out_valid || out_ready))

endmodule
`default_nettype wire

[bench/drmp_step_checker.sv]
// step checker for the drive motor speed ramp unit: watches the command and step channels,
// predicts the drive steps of each accepted command and compares them in order
// depends on drmp_pkg
module drmp_step_checker
    import drmp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  cfg_idx_t          cfg_index,
    input  cfg_data_t         cfg_data,
    input  logic              in_valid,
    input  logic              in_ready,
    input  logic signed [8:0] target_speed,
    input  logic              out_valid,
    input  logic              out_ready,
    input  logic [9:0]        pwm_duty,
    input  logic              bridge_a,
    input  logic              bridge_b,
    input  logic [7:0]        hold_ms,
    input  logic              last_step,
    output int                mismatches,
    output int                pending,
    output int                cmds_seen,
    output int                steps_seen
);

    typedef struct packed {
        duty_t duty;
        logic  a;
        logic  b;
        hold_t hold;
        logic  last;
    } drive_step_t;

    drive_step_t step_q[$];
    drive_step_t want;
    speed_t      cur_speed;
    dir_t        cur_dir;
    speed_t      ramp_thr;
    hold_t       bump_hold;
    duty_t       bump_pwm;

    initial begin
        mismatches = 0;
        cmds_seen  = 0;
        steps_seen = 0;
    end

    task automatic report(input string msg);
        $display("%0t: %s", $time, msg);
        mismatches++;
    endtask

    function automatic void push_step(input duty_t duty, input hold_t hold);
        drive_step_t s;
        s.duty = duty;
        s.hold = hold;
        s.last = 1'b0;
        case (cur_dir)
            DIR_FWD: begin s.a = 1'b0; s.b = 1'b1; end
            DIR_REV: begin s.a = 1'b1; s.b = 1'b0; end
            default: begin s.a = 1'b1; s.b = 1'b1; end
        endcase
        step_q.push_back(s);
    endfunction

    function automatic void predict_drive(input logic signed [8:0] cmd);
        int          mag;
        int          first;
        int unsigned from_speed;
        int unsigned diff;
        int unsigned frac;
        dir_t        want_dir;
        first = step_q.size();
        if (cmd == 0) begin
            mag      = 0;
            want_dir = DIR_COAST;
        end else if (cmd < 0) begin
            mag      = -int'(cmd);
            if (mag > 255)
                mag = 255;
            want_dir = DIR_REV;
        end else begin
            mag      = int'(cmd);
            want_dir = DIR_FWD;
        end
        if (want_dir != cur_dir) begin
            cur_speed = '0;
            cur_dir   = want_dir;
            push_step('0, '0);
        end
        if (cur_speed < mag) begin
            from_speed = 32'(cur_speed);
            diff       = mag - from_speed;
            if (from_speed == 0)
                push_step(bump_pwm, bump_hold);
            if (diff > ramp_thr) begin
                frac = diff / RAMP_STEPS;
                for (int i = 1; i < RAMP_STEPS; i++)
                    push_step(duty_t'((from_speed + frac * i) * 4), hold_t'(frac));
            end
            push_step(duty_t'(mag * 4), '0);
            cur_speed = speed_t'(mag);
        end else if (cur_speed > mag) begin
            push_step(duty_t'(mag * 4), '0);
            cur_speed = speed_t'(mag);
        end
        if (step_q.size() > first)
            step_q[step_q.size() - 1].last = 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_q.delete();
            cur_speed = '0;
            cur_dir   = DIR_COAST;
            ramp_thr  = RST_RAMP_THRESHOLD;
            bump_hold = RST_BUMP_HOLD_MS;
            bump_pwm  = RST_BUMP_DUTY;
            pending  <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_RAMP_THRESHOLD: ramp_thr  = cfg_data[SPEED_W-1:0];
                    REG_BUMP_HOLD_MS:   bump_hold = cfg_data[HOLD_W-1:0];
                    REG_BUMP_DUTY:      bump_pwm  = cfg_data[DUTY_W-1:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                cmds_seen++;
                predict_drive(target_speed);
            end
            if (out_valid && out_ready)
            begin
                steps_seen++;
                if (step_q.size() == 0)
                    report($sformatf("step %0d with nothing pending: duty %0d bridge %b%b hold %0d",
                        steps_seen, pwm_duty, bridge_a, bridge_b, hold_ms));
                else
                begin
                    want = step_q.pop_front();
                    if (pwm_duty !== want.duty)
                        report($sformatf("step %0d pwm_duty %0d, expected %0d",
                            steps_seen, pwm_duty, want.duty));
                    if (bridge_a !== want.a)
                        report($sformatf("step %0d bridge_a %b, expected %b",
                            steps_seen, bridge_a, want.a));
                    if (bridge_b !== want.b)
                        report($sformatf("step %0d bridge_b %b, expected %b",
                            steps_seen, bridge_b, want.b));
                    if (hold_ms !== want.hold)
                        report($sformatf("step %0d hold_ms %0d, expected %0d",
                            steps_seen, hold_ms, want.hold));
                    if (last_step !== want.last)
                        report($sformatf("step %0d last_step %b, expected %b",
                            steps_seen, last_step, want.last));
                end
            end
            pending <= step_q.size();
        end
    end

endmodule

[bench/tb_top.sv]
// top of the drive motor speed ramp unit testbench: clock, reset, register settings,
// speed command and step stall patterns; checking is done by drmp_step_checker
// depends on drmp_pkg, drmp_step_checker and the unit itself
module tb_top;
    import drmp_pkg::*;

    localparam int PHASES        = 6;
    localparam int PHASE_ITEMS   = 65;
    localparam int LONG_HOLD     = 150;
    localparam int SETTLE_CYCLES = 16;
    localparam int DRAIN_LIMIT   = 20000;

    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              cfg_we       = 1'b0;
    cfg_idx_t          cfg_index    = REG_RAMP_THRESHOLD;
    cfg_data_t         cfg_data     = '0;
    logic              in_valid     = 1'b0;
    logic              in_ready;
    logic signed [8:0] target_speed = '0;
    logic              out_valid;
    logic              out_ready    = 1'b0;
    logic [9:0]        pwm_duty;
    logic              bridge_a;
    logic              bridge_b;
    logic [7:0]        hold_ms;
    logic              last_step;

    int mismatches;
    int pending;
    int cmds_seen;
    int steps_seen;
    int settings_used = 0;
    int last_target   = 0;
    bit hold_off_req  = 1'b0;

    int directed_cmds [20] = '{0, 255, 255, 100, -256, -1, 0, 0, 1, 40,
                               72, 71, 103, 134, -255, 255, -100, -68, 0, 3};

    drive_motor_speed_ramp_unit i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .target_speed (target_speed),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .pwm_duty     (pwm_duty),
        .bridge_a     (bridge_a),
        .bridge_b     (bridge_b),
        .hold_ms      (hold_ms),
        .last_step    (last_step)
    );

    drmp_step_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .target_speed (target_speed),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .pwm_duty     (pwm_duty),
        .bridge_a     (bridge_a),
        .bridge_b     (bridge_b),
        .hold_ms      (hold_ms),
        .last_step    (last_step),
        .mismatches   (mismatches),
        .pending      (pending),
        .cmds_seen    (cmds_seen),
        .steps_seen   (steps_seen)
    );

    always #4 clk = ~clk;

    initial
    begin
        #8_000_000;
        $display("drive_motor_speed_ramp_unit: mismatch");
        $finish;
    end

    task automatic send_cmd(input int v);
        in_valid     <= 1'b1;
        target_speed <= v[8:0];
        last_target   = v;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic idle_sender(input int cycles);
        if (cycles > 0)
        begin
            in_valid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input int val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= cfg_data_t'(val);
        @(posedge clk);
    endtask

    task automatic apply_setting(input int thr, input int bump_hold, input int bump_pwm);
        write_reg(REG_RAMP_THRESHOLD, thr);
        write_reg(REG_BUMP_HOLD_MS, bump_hold);
        write_reg(REG_BUMP_DUTY, bump_pwm);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    function automatic int pick_target();
        int v;
        int d;
        d = int'($urandom_range(0, 52)) - 12;
        case ($urandom_range(0, 9))
            0: v = 0;
            1: v = last_target;
            2: v = $urandom_range(0, 1) ? 255 : ($urandom_range(0, 1) ? -255 : -256);
            3, 4: v = (last_target < 0) ? last_target - d : last_target + d;
            5: v = -last_target;
            default: v = int'($urandom_range(0, 511)) - 256;
        endcase
        if (v > 255)
            v = 255;
        if (v < -256)
            v = -256;
        return v;
    endfunction

    // receiver stall pattern, with long hold-offs on request
    initial
    begin : receiver
        int mode;
        int len;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                out_ready   <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else
            begin
                mode = $urandom_range(0, 3);
                len  = $urandom_range(4, 40);
                repeat (len)
                begin
                    case (mode)
                        0: out_ready <= 1'b1;
                        1: out_ready <= ($urandom_range(0, 3) != 0);
                        2: out_ready <= 1'($urandom_range(0, 1));
                        default: out_ready <= ($urandom_range(0, 4) == 0);
                    endcase
                    @(posedge clk);
                end
            end
        end
    end

    initial
    begin : stimulus
        int burst;
        int waited;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_cmds[k])
        begin
            send_cmd(directed_cmds[k]);
            idle_sender($urandom_range(0, 3));
        end

        for (int p = 0; p < PHASES; p++)
        begin
            settle();
            case (p)
                0: apply_setting(0, 0, 0);
                1: apply_setting(255, 255, 1023);
                2: apply_setting(7, 1, 512);
                default: apply_setting($urandom_range(0, 1) ? $urandom_range(0, 40)
                                                            : $urandom_range(0, 255),
                                       $urandom_range(0, 255), $urandom_range(0, 1023));
            endcase
            if (p == 0 || p == 3)
                hold_off_req = 1'b1;
            burst = 0;
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                if (burst == 0)
                begin
                    idle_sender($urandom_range(1, 15));
                    burst = $urandom_range(1, 20);
                end
                send_cmd(pick_target());
                burst--;
            end
        end

        in_valid <= 1'b0;
        @(posedge clk);
        waited = 0;
        while (pending != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("covered %0d speed commands and %0d drive steps", cmds_seen, steps_seen);
        $display("under reset and %0d register settings, with stalls on both sides",
            settings_used);
        if (mismatches == 0 && pending == 0)
            $display("drive_motor_speed_ramp_unit: match");
        else
            $display("drive_motor_speed_ramp_unit: mismatch");
        $finish;
    end

endmodule

[filelist.f]
+incdir+design
design/drmp_pkg.sv
design/drmp_datapath.sv
design/drmp_ctrl.sv
design/drive_motor_speed_ramp_unit.sv
bench/drmp_step_checker.sv
bench/tb_top.sv
